// ===== design/ev_charge_pilot_state_machine_macros.svh =====
// Assertion macros shared by the pilot state machine RTL.
`ifndef EV_CHARGE_PILOT_STATE_MACHINE_MACROS_SVH
`define EV_CHARGE_PILOT_STATE_MACHINE_MACROS_SVH

`ifndef SYNTHESIS
`define ECP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pilot state machine check failed");
`define ECP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pilot state machine check failed");
`else
`define ECP_ASSERT(label, clk, rst, prop)
`define ECP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== design/ecp_pkg.sv =====
package ecp_pkg;

   localparam int unsigned DIODE_ERROR_LIMIT = 100;
   localparam int unsigned DIODE_CNT_W       = 7;
   localparam int unsigned CSR_INDEX_W       = 4;
   localparam int unsigned CSR_DATA_W        = 16;

   localparam logic [15:0] ERROR_HOLDOFF_RESET   = 16'd30000;
   localparam logic [15:0] RESTART_HOLDOFF_RESET = 16'd5000;

   localparam logic [9:0]  DUTY_FULL        = 10'd1000;
   localparam logic [11:0] DUTY_MIN         = 12'd80;
   localparam logic [11:0] DUTY_MAX         = 12'd1000;
   localparam logic [16:0] DUTY_SPLIT_MA    = 17'd51000;
   localparam logic [10:0] DUTY_HIGH_OFFSET = 11'd640;
   // floor(x/15) for x < 2^14 and floor(x/125) for x < 2^16, exact
   localparam logic [14:0] DIV15_MUL    = 15'd17477;
   localparam int unsigned DIV15_SHIFT  = 18;
   localparam logic [16:0] DIV125_MUL   = 17'd67109;
   localparam int unsigned DIV125_SHIFT = 23;

   localparam logic signed [15:0] V1_LIMIT_MV   = -16'sd10000;
   localparam logic signed [16:0] VDIFF_LIMIT_MV = 17'sd2000;

   localparam logic [2:0] LED_STEADY  = 3'd0;
   localparam logic [2:0] LED_BLINK2  = 3'd2;
   localparam logic [2:0] LED_BLINK3  = 3'd3;
   localparam logic [2:0] LED_BLINK4  = 3'd4;
   localparam logic [2:0] LED_BLINK5  = 3'd5;
   localparam logic [2:0] LED_BREATHE = 3'd6;

   typedef enum logic [2:0] {
      ST_A  = 3'd0,
      ST_B  = 3'd1,
      ST_C  = 3'd2,
      ST_D  = 3'd3,
      ST_EF = 3'd4
   } pilot_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ERROR_HOLDOFF   = 4'd0,
      CSR_RESTART_HOLDOFF = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [31:0]        now_ms;
      logic               pe_error;
      logic               dc_leak_error;
      logic               contactor_error;
      logic               jumper_invalid;
      logic               cp_usable;
      logic [15:0]        cp_resistance;
      logic [16:0]        max_current_ma;
      logic signed [15:0] vcp1_negative_mv;
      logic signed [15:0] vcp2_negative_mv;
      logic               measurement_settling;
      logic               phase_switch_busy;
   } item_type;

   typedef struct packed {
      pilot_type              pilot;
      logic [DIODE_CNT_W-1:0] diode_cnt;
      logic [31:0]            err_time;
      logic                   err_valid;
      logic [31:0]            chg_time;
      logic                   chg_valid;
      logic [2:0]             led;
      logic [9:0]             duty;
      logic                   contactor;
   } state_type;

   localparam state_type STATE_RESET = '{
      pilot:     ST_A,
      diode_cnt: '0,
      err_time:  '0,
      err_valid: 1'b0,
      chg_time:  '0,
      chg_valid: 1'b0,
      led:       LED_STEADY,
      duty:      DUTY_FULL,
      contactor: 1'b0
   };

   typedef struct packed {
      logic [15:0] error_holdoff;
      logic [15:0] restart_holdoff;
   } cfg_type;

   typedef struct packed {
      logic [2:0] pilot_state_out;
      logic [9:0] duty_permille;
      logic       contactor_on;
      logic [2:0] led_pattern;
      logic       diode_fault;
   } result_type;

   typedef struct packed {
      logic [15:0] to_a;
      logic [15:0] to_b;
      logic [15:0] to_c;
      logic [15:0] to_d;
   } thresh_type;

   function automatic thresh_type pilot_thresh(pilot_type p);
      thresh_type t;
      case (p)
         ST_A:    t = '{to_a: 16'd9000,  to_b: 16'd1790, to_c: 16'd300, to_d: 16'd150};
         ST_B:    t = '{to_a: 16'd11000, to_b: 16'd1611, to_c: 16'd300, to_d: 16'd150};
         ST_C:    t = '{to_a: 16'd10000, to_b: 16'd1969, to_c: 16'd270, to_d: 16'd150};
         ST_D:    t = '{to_a: 16'd10000, to_b: 16'd1790, to_c: 16'd330, to_d: 16'd135};
         default: t = '{to_a: 16'd10000, to_b: 16'd1790, to_c: 16'd300, to_d: 16'd165};
      endcase
      return t;
   endfunction

endpackage

// ===== design/ecp_if.sv =====
interface ecp_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        now_ms;
   logic               pe_error;
   logic               dc_leak_error;
   logic               contactor_error;
   logic               jumper_invalid;
   logic               cp_usable;
   logic [15:0]        cp_resistance;
   logic [16:0]        max_current_ma;
   logic signed [15:0] vcp1_negative_mv;
   logic signed [15:0] vcp2_negative_mv;
   logic               measurement_settling;
   logic               phase_switch_busy;

   modport source (
      output valid, now_ms, pe_error, dc_leak_error, contactor_error, jumper_invalid,
             cp_usable, cp_resistance, max_current_ma, vcp1_negative_mv,
             vcp2_negative_mv, measurement_settling, phase_switch_busy,
      input  ready
   );
   modport sink (
      input  valid, now_ms, pe_error, dc_leak_error, contactor_error, jumper_invalid,
             cp_usable, cp_resistance, max_current_ma, vcp1_negative_mv,
             vcp2_negative_mv, measurement_settling, phase_switch_busy,
      output ready
   );
endinterface

interface ecp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] pilot_state_out;
   logic [9:0] duty_permille;
   logic       contactor_on;
   logic [2:0] led_pattern;
   logic       diode_fault;

   modport source (
      output valid, pilot_state_out, duty_permille, contactor_on, led_pattern,
             diode_fault,
      input  ready
   );
   modport sink (
      input  valid, pilot_state_out, duty_permille, contactor_on, led_pattern,
             diode_fault,
      output ready
   );
endinterface

interface ecp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ecp_pkg::CSR_INDEX_W-1:0]    index;
   logic [ecp_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/ecp_duty.sv =====
module ecp_duty (
   input  logic [16:0] max_current_ma,
   output logic [9:0]  duty
);
   import ecp_pkg::*;

   logic [14:0] quarter;
   logic [29:0] prod60;
   logic [11:0] q60;
   logic [15:0] half;
   logic [32:0] prod250;
   logic [9:0]  q250;
   logic [11:0] raw;

   assign quarter = max_current_ma[16:2];
   assign prod60  = 30'(quarter) * 30'(DIV15_MUL);
   assign q60     = prod60[DIV15_SHIFT +: 12];
   assign half    = max_current_ma[16:1];
   assign prod250 = 33'(half) * 33'(DIV125_MUL);
   assign q250    = prod250[DIV125_SHIFT +: 10];

   always_comb begin
      if (max_current_ma <= DUTY_SPLIT_MA) begin
         raw = q60;
      end else begin
         raw = 12'(11'(q250) + DUTY_HIGH_OFFSET);
      end
      if (max_current_ma == 17'd0) begin
         duty = DUTY_FULL;
      end else if (raw < DUTY_MIN) begin
         duty = 10'(DUTY_MIN);
      end else if (raw > DUTY_MAX) begin
         duty = 10'(DUTY_MAX);
      end else begin
         duty = raw[9:0];
      end
   end
endmodule

// ===== design/ecp_step.sv =====
module ecp_step (
   input  ecp_pkg::state_type st,
   input  ecp_pkg::item_type  item,
   input  ecp_pkg::cfg_type   cfg,
   output ecp_pkg::state_type st_next
);
   import ecp_pkg::*;

   logic              [9:0] duty;
   logic signed      [16:0] vdiff;
   logic signed      [16:0] vdiff_abs;
   logic                    diode_bad;
   thresh_type              thr;

   ecp_duty u_duty (
      .max_current_ma (item.max_current_ma),
      .duty           (duty)
   );

   assign vdiff     = {item.vcp1_negative_mv[15], item.vcp1_negative_mv}
                    - {item.vcp2_negative_mv[15], item.vcp2_negative_mv};
   assign vdiff_abs = (vdiff < 0) ? -vdiff : vdiff;
   assign thr       = pilot_thresh(st.pilot);

   assign diode_bad = (st.pilot == ST_B || st.pilot == ST_C)
                   && item.vcp1_negative_mv != 16'sd0
                   && item.vcp2_negative_mv != 16'sd0
                   && (item.vcp1_negative_mv > V1_LIMIT_MV || vdiff_abs > VDIFF_LIMIT_MV)
                   && item.cp_usable
                   && item.max_current_ma != 17'd0
                   && !item.phase_switch_busy;

   always_comb begin
      state_type   s;
      logic        go;
      logic        hold;
      logic        blocked;
      pilot_type   tgt;
      pilot_type   cur;
      logic [31:0] since_err;
      logic [31:0] since_chg;

      s         = st;
      go        = 1'b0;
      hold      = 1'b0;
      blocked   = 1'b0;
      tgt       = ST_A;
      cur       = st.pilot;
      since_err = '0;
      since_chg = '0;

      if (item.pe_error) begin
         s.led = LED_BLINK4;
         go    = 1'b1;
         tgt   = ST_EF;
      end else if (item.dc_leak_error) begin
         s.led = LED_BLINK3;
         go    = 1'b1;
         tgt   = ST_EF;
      end else if (item.contactor_error) begin
         s.led = LED_BLINK4;
         go    = 1'b1;
         tgt   = ST_EF;
      end else if (item.jumper_invalid) begin
         s.led = LED_BLINK2;
         go    = 1'b1;
         tgt   = ST_EF;
      end else if (diode_bad) begin
         if (item.measurement_settling) begin
            hold = 1'b1;
         end else if (st.pilot == ST_B || st.diode_cnt >= DIODE_CNT_W'(DIODE_ERROR_LIMIT)) begin
            s.diode_cnt = DIODE_CNT_W'(DIODE_ERROR_LIMIT);
            s.led       = LED_BLINK5;
            s.pilot     = ST_B;
         end else begin
            s.diode_cnt = st.diode_cnt + 1'b1;
         end
      end else if (item.measurement_settling) begin
         hold = 1'b1;
      end else begin
         if (st.diode_cnt != '0) begin
            s.diode_cnt = st.diode_cnt - 1'b1;
            if (s.diode_cnt == '0) begin
               s.led = LED_STEADY;
            end else begin
               hold = 1'b1;
            end
         end
         if (!hold && item.phase_switch_busy) begin
            hold = 1'b1;
         end
         if (!hold && item.cp_usable) begin
            go = 1'b1;
            if (item.cp_resistance > thr.to_a) begin
               tgt = ST_A;
            end else if (item.cp_resistance > thr.to_b) begin
               tgt = ST_B;
            end else if (item.cp_resistance > thr.to_c) begin
               tgt = (item.max_current_ma == 17'd0) ? ST_B : ST_C;
            end else if (item.cp_resistance > thr.to_d) begin
               s.led = LED_BLINK5;
               tgt   = ST_D;
            end else begin
               s.led = LED_BLINK5;
               tgt   = ST_EF;
            end
         end
      end

      if (go && tgt != s.pilot) begin
         cur = s.pilot;
         if ((cur == ST_D && !s.err_valid) || cur == ST_EF) begin
            s.err_time  = item.now_ms;
            s.err_valid = 1'b1;
         end
         since_err = item.now_ms - s.err_time;
         if (tgt == ST_C && s.err_valid) begin
            if (since_err < {16'd0, cfg.error_holdoff}) begin
               blocked = 1'b1;
            end else begin
               s.err_valid = 1'b0;
            end
         end
         if (!blocked) begin
            if (cur == ST_C) begin
               s.chg_time  = item.now_ms;
               s.chg_valid = 1'b1;
            end
            since_chg = item.now_ms - s.chg_time;
            if (tgt == ST_C && s.chg_valid) begin
               if (since_chg < {16'd0, cfg.restart_holdoff}) begin
                  blocked = 1'b1;
               end else begin
                  s.chg_valid = 1'b0;
               end
            end
         end
         if (!blocked) begin
            if (tgt == ST_A || tgt == ST_B) begin
               s.led = LED_STEADY;
            end
            if (tgt == ST_A || tgt == ST_D || tgt == ST_EF) begin
               s.diode_cnt = '0;
            end
            s.pilot = tgt;
         end
      end

      if (!hold) begin
         case (s.pilot)
            ST_B: begin
               s.duty      = duty;
               s.contactor = 1'b0;
            end
            ST_C: begin
               s.duty      = duty;
               s.contactor = 1'b1;
               s.led       = LED_BREATHE;
            end
            default: begin
               s.duty      = DUTY_FULL;
               s.contactor = 1'b0;
            end
         endcase
      end

      st_next = s;
   end
endmodule

// ===== design/ev_charge_pilot_state_machine.sv =====
// Control-pilot state machine for an AC charging point. Each request transaction is one
// tick: fault flags, pilot measurements and the offered current go in, and exactly one
// response transaction comes back with the pilot state, PWM duty in per mille, contactor
// enable, LED pattern and diode fault flag as they stand after that tick. Sustained rate
// is one tick per clock unless responses stall. A tick's response is registered: the
// request register feeds the next-state logic, which loads the state and response
// registers together. A stalled response stops the state update and the request side
// fills one register deep before ready drops. Holdoff registers are written through the
// csr channel, by the user only while no tick is in flight; the block does not check.
`include "ev_charge_pilot_state_machine_macros.svh"

module ev_charge_pilot_state_machine (
   input logic        clock,
   input logic        reset,
   ecp_req_if.sink    req_chan,
   ecp_rsp_if.source  rsp_chan,
   ecp_csr_if.sink    csr_chan
);
   import ecp_pkg::*;

   item_type   item_ff;
   logic       in_valid_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type rsp_in;
   state_type  st_ff;
   state_type  st_in;
   cfg_type    cfg_ff;
   item_type   req_item;
   logic       advance;

   ecp_step u_step (
      .st      (st_ff),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .st_next (st_in)
   );

   assign req_item = '{
      now_ms:               req_chan.now_ms,
      pe_error:             req_chan.pe_error,
      dc_leak_error:        req_chan.dc_leak_error,
      contactor_error:      req_chan.contactor_error,
      jumper_invalid:       req_chan.jumper_invalid,
      cp_usable:            req_chan.cp_usable,
      cp_resistance:        req_chan.cp_resistance,
      max_current_ma:       req_chan.max_current_ma,
      vcp1_negative_mv:     req_chan.vcp1_negative_mv,
      vcp2_negative_mv:     req_chan.vcp2_negative_mv,
      measurement_settling: req_chan.measurement_settling,
      phase_switch_busy:    req_chan.phase_switch_busy
   };

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_in = '{
      pilot_state_out: st_in.pilot,
      duty_permille:   st_in.duty,
      contactor_on:    st_in.contactor,
      led_pattern:     st_in.led,
      diode_fault:     st_in.diode_cnt != '0
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         st_ff                  <= STATE_RESET;
         cfg_ff.error_holdoff   <= ERROR_HOLDOFF_RESET;
         cfg_ff.restart_holdoff <= RESTART_HOLDOFF_RESET;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            st_ff        <= st_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_chan.valid) begin
            case (csr_index_type'(csr_chan.index))
               CSR_ERROR_HOLDOFF:   cfg_ff.error_holdoff   <= csr_chan.data;
               CSR_RESTART_HOLDOFF: cfg_ff.restart_holdoff <= csr_chan.data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.pilot_state_out = rsp_ff.pilot_state_out;
   assign rsp_chan.duty_permille   = rsp_ff.duty_permille;
   assign rsp_chan.contactor_on    = rsp_ff.contactor_on;
   assign rsp_chan.led_pattern     = rsp_ff.led_pattern;
   assign rsp_chan.diode_fault     = rsp_ff.diode_fault;

   `ECP_ASSERT(a_state_hold, clock, reset, !advance |=> $stable(st_ff))
   `ECP_ASSERT(a_rsp_after_tick, clock, reset, advance |=> rsp_valid_ff)
   `ECP_ASSERT(a_contactor_only_c, clock, reset, st_ff.contactor |-> st_ff.pilot == ST_C)
   `ECP_ASSERT(a_diode_limit, clock, reset, st_ff.diode_cnt <= DIODE_CNT_W'(DIODE_ERROR_LIMIT))
   `ECP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid_ff && !in_valid_ff)

endmodule

// ===== bench/pilot_checker.sv =====
module pilot_checker
   import ecp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ecp_req_if   req_mon,
   ecp_rsp_if   rsp_mon,
   ecp_csr_if   csr_mon,
   output int   fail_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] err_holdoff;
   logic [15:0] rst_holdoff;
   pilot_type   pilot;
   int unsigned diode_cnt;
   logic [31:0] err_left_at;
   logic        err_left_set;
   logic [31:0] chg_end_at;
   logic        chg_end_set;
   logic [2:0]  led;
   logic [9:0]  duty;
   logic        contactor;
   int          fails;
   result_type  status_q[$];

   // hysteresis rows, one per pilot state; columns: above A, above B, above C, above D
   logic [15:0] thr [5][4] = '{
      '{16'd9000,  16'd1790, 16'd300, 16'd150},
      '{16'd11000, 16'd1611, 16'd300, 16'd150},
      '{16'd10000, 16'd1969, 16'd270, 16'd150},
      '{16'd10000, 16'd1790, 16'd330, 16'd135},
      '{16'd10000, 16'd1790, 16'd300, 16'd165}
   };

   function automatic logic [9:0] duty_for_current(logic [16:0] ma);
      int unsigned d;
      if (ma == 0) return DUTY_FULL;
      if (ma <= DUTY_SPLIT_MA) d = int'(ma) / 60;
      else d = int'(ma) / 250 + int'(DUTY_HIGH_OFFSET);
      if (d < DUTY_MIN) d = DUTY_MIN;
      if (d > DUTY_MAX) d = DUTY_MAX;
      return d[9:0];
   endfunction

   function automatic void enter(pilot_type nxt, logic [31:0] now);
      if (nxt == pilot) return;
      if (pilot == ST_D && !err_left_set) begin
         err_left_at = now;
         err_left_set = 1'b1;
      end
      if (pilot == ST_EF) begin
         err_left_at = now;
         err_left_set = 1'b1;
      end
      if (nxt == ST_C && err_left_set) begin
         if (now - err_left_at < 32'(err_holdoff)) return;
         err_left_set = 1'b0;
      end
      if (pilot == ST_C) begin
         chg_end_at = now;
         chg_end_set = 1'b1;
      end
      if (nxt == ST_C && chg_end_set) begin
         if (now - chg_end_at < 32'(rst_holdoff)) return;
         chg_end_set = 1'b0;
      end
      if (nxt == ST_A || nxt == ST_B) led = LED_STEADY;
      if (nxt == ST_A || nxt == ST_D || nxt == ST_EF) diode_cnt = 0;
      pilot = nxt;
   endfunction

   function automatic result_type status_now();
      result_type r;
      r.pilot_state_out = pilot;
      r.duty_permille   = duty;
      r.contactor_on    = contactor;
      r.led_pattern     = led;
      r.diode_fault     = (diode_cnt != 0);
      return r;
   endfunction

   function automatic result_type pilot_tick(item_type it);
      int          v1;
      int          v2;
      int          gap;
      logic        in_bc;
      logic [15:0] lim [4];
      v1 = int'($signed(it.vcp1_negative_mv));
      v2 = int'($signed(it.vcp2_negative_mv));
      gap = v1 - v2;
      if (gap < 0) gap = -gap;
      in_bc = (pilot == ST_B || pilot == ST_C);
      if (it.pe_error) begin
         led = LED_BLINK4;
         enter(ST_EF, it.now_ms);
      end else if (it.dc_leak_error) begin
         led = LED_BLINK3;
         enter(ST_EF, it.now_ms);
      end else if (it.contactor_error) begin
         led = LED_BLINK4;
         enter(ST_EF, it.now_ms);
      end else if (it.jumper_invalid) begin
         led = LED_BLINK2;
         enter(ST_EF, it.now_ms);
      end else if (in_bc && v1 != 0 && v2 != 0 &&
                   (v1 > int'(V1_LIMIT_MV) || gap > int'(VDIFF_LIMIT_MV)) &&
                   it.cp_usable && it.max_current_ma != 0 && !it.phase_switch_busy) begin
         if (it.measurement_settling) return status_now();
         if (pilot == ST_B || diode_cnt >= DIODE_ERROR_LIMIT) begin
            diode_cnt = DIODE_ERROR_LIMIT;
            led = LED_BLINK5;
            pilot = ST_B;
         end else begin
            diode_cnt++;
         end
      end else begin
         if (it.measurement_settling) return status_now();
         if (diode_cnt > 0) begin
            diode_cnt--;
            if (diode_cnt == 0) led = LED_STEADY;
            else return status_now();
         end
         if (it.phase_switch_busy) return status_now();
         if (it.cp_usable) begin
            lim = thr[int'(pilot)];
            if (it.cp_resistance > lim[0]) begin
               enter(ST_A, it.now_ms);
            end else if (it.cp_resistance > lim[1]) begin
               enter(ST_B, it.now_ms);
            end else if (it.cp_resistance > lim[2]) begin
               enter(it.max_current_ma == 0 ? ST_B : ST_C, it.now_ms);
            end else if (it.cp_resistance > lim[3]) begin
               led = LED_BLINK5;
               enter(ST_D, it.now_ms);
            end else begin
               led = LED_BLINK5;
               enter(ST_EF, it.now_ms);
            end
         end
      end
      case (pilot)
         ST_B: begin
            duty = duty_for_current(it.max_current_ma);
            contactor = 1'b0;
         end
         ST_C: begin
            duty = duty_for_current(it.max_current_ma);
            contactor = 1'b1;
            led = LED_BREATHE;
         end
         default: begin
            duty = DUTY_FULL;
            contactor = 1'b0;
         end
      endcase
      return status_now();
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      item_type   it;
      result_type got;
      result_type want;
      if (reset) begin
         err_holdoff  = ERROR_HOLDOFF_RESET;
         rst_holdoff  = RESTART_HOLDOFF_RESET;
         pilot        = ST_A;
         diode_cnt    = 0;
         err_left_at  = '0;
         err_left_set = 1'b0;
         chg_end_at   = '0;
         chg_end_set  = 1'b0;
         led          = LED_STEADY;
         duty         = DUTY_FULL;
         contactor    = 1'b0;
         fails        = 0;
         status_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_ERROR_HOLDOFF:   err_holdoff = csr_mon.data;
               CSR_RESTART_HOLDOFF: rst_holdoff = csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.pilot_state_out = rsp_mon.pilot_state_out;
            got.duty_permille   = rsp_mon.duty_permille;
            got.contactor_on    = rsp_mon.contactor_on;
            got.led_pattern     = rsp_mon.led_pattern;
            got.diode_fault     = rsp_mon.diode_fault;
            if (status_q.size() == 0) begin
               $error("response transaction with no expected status waiting");
               fails++;
            end else begin
               want = status_q.pop_front();
               check_field("pilot_state_out", want.pilot_state_out, got.pilot_state_out);
               check_field("duty_permille", want.duty_permille, got.duty_permille);
               check_field("contactor_on", want.contactor_on, got.contactor_on);
               check_field("led_pattern", want.led_pattern, got.led_pattern);
               check_field("diode_fault", want.diode_fault, got.diode_fault);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            it.now_ms               = req_mon.now_ms;
            it.pe_error             = req_mon.pe_error;
            it.dc_leak_error        = req_mon.dc_leak_error;
            it.contactor_error      = req_mon.contactor_error;
            it.jumper_invalid       = req_mon.jumper_invalid;
            it.cp_usable            = req_mon.cp_usable;
            it.cp_resistance        = req_mon.cp_resistance;
            it.max_current_ma       = req_mon.max_current_ma;
            it.vcp1_negative_mv     = req_mon.vcp1_negative_mv;
            it.vcp2_negative_mv     = req_mon.vcp2_negative_mv;
            it.measurement_settling = req_mon.measurement_settling;
            it.phase_switch_busy    = req_mon.phase_switch_busy;
            status_q.push_back(pilot_tick(it));
         end
      end
      outstanding <= status_q.size();
      fail_count  <= fails;
   end

endmodule

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ecp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          fail_count;
   int          outstanding;
   logic        calm = 1'b0;
   logic [31:0] tick_ms;
   int          sent = 0;

   ecp_req_if req_bus ();
   ecp_rsp_if rsp_bus ();
   ecp_csr_if csr_bus ();

   ev_charge_pilot_state_machine u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   pilot_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("ev_charge_pilot_state_machine regression: fail");
      $finish;
   end

   function automatic int pause_len();
      if (calm || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 8);
   endfunction

   // response side: stall at random, hold ready across back-to-back transactions
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         n = pause_len();
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
      end
   end

   task automatic send(item_type it);
      int n;
      n = pause_len();
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_bus.now_ms               <= it.now_ms;
      req_bus.pe_error             <= it.pe_error;
      req_bus.dc_leak_error        <= it.dc_leak_error;
      req_bus.contactor_error      <= it.contactor_error;
      req_bus.jumper_invalid       <= it.jumper_invalid;
      req_bus.cp_usable            <= it.cp_usable;
      req_bus.cp_resistance        <= it.cp_resistance;
      req_bus.max_current_ma       <= it.max_current_ma;
      req_bus.vcp1_negative_mv     <= it.vcp1_negative_mv;
      req_bus.vcp2_negative_mv     <= it.vcp2_negative_mv;
      req_bus.measurement_settling <= it.measurement_settling;
      req_bus.phase_switch_busy    <= it.phase_switch_busy;
      req_bus.valid                <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sent++;
   endtask

   // drop valid and wait until every expected status has come back
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] v);
      csr_bus.index <= idx;
      csr_bus.data  <= v;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int rand_step();
      case ($urandom_range(0, 15))
         0:       return $urandom_range(0, 70000);
         1:       return 0;
         default: return $urandom_range(1, 200);
      endcase
   endfunction

   function automatic item_type make_tick(logic [15:0] res, logic [16:0] ma, int step);
      item_type it;
      int       m;
      int       hi;
      tick_ms += 32'(step);
      it = '0;
      it.now_ms = tick_ms;
      it.cp_usable = 1'b1;
      it.cp_resistance = res;
      it.max_current_ma = ma;
      m = $urandom_range(10000, 20000);
      hi = m + 2000;
      if (hi > 20000) hi = 20000;
      it.vcp1_negative_mv = 16'(-m);
      it.vcp2_negative_mv = 16'(-int'($urandom_range(m - 2000, hi)));
      case ($urandom_range(0, 19))
         0:       it.vcp1_negative_mv = '0;
         1:       it.vcp2_negative_mv = '0;
         default: ;
      endcase
      return it;
   endfunction

   function automatic item_type make_diode(item_type it);
      int m;
      if ($urandom_range(0, 1) == 0) begin
         it.vcp1_negative_mv = 16'(-int'($urandom_range(1, 9999)));
         it.vcp2_negative_mv = 16'(-int'($urandom_range(1, 20000)));
      end else begin
         m = $urandom_range(10000, 20000);
         it.vcp1_negative_mv = 16'(-m);
         it.vcp2_negative_mv = 16'(-int'($urandom_range(1, m - 2001)));
      end
      return it;
   endfunction

   function automatic item_type roughen(item_type it);
      if ($urandom_range(0, 19) == 0) it.measurement_settling = 1'b1;
      if ($urandom_range(0, 24) == 0) it.phase_switch_busy = 1'b1;
      if ($urandom_range(0, 29) == 0) it.cp_usable = 1'b0;
      return it;
   endfunction

   function automatic logic [16:0] pick_ma();
      int edges [11] = '{1, 59, 60, 4799, 4800, 4859, 51000, 51001, 51249, 51250, 80000};
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 17'(edges[$urandom_range(0, 10)]);
         2:       return 17'($urandom_range(80001, 131071));
         default: return 17'($urandom_range(1, 80000));
      endcase
   endfunction

   function automatic logic [16:0] pick_live_ma();
      logic [16:0] m;
      m = pick_ma();
      if (m == 0) m = 17'($urandom_range(1, 80000));
      return m;
   endfunction

   function automatic logic [15:0] pick_res(pilot_type zone);
      int edges [12] = '{9000, 11000, 10000, 1790, 1611, 1969, 300, 270, 330, 150, 135, 165};
      if ($urandom_range(0, 5) == 0)
         return 16'(edges[$urandom_range(0, 11)] + $urandom_range(0, 2) - 1);
      case (zone)
         ST_A:    return 16'($urandom_range(11001, 65535));
         ST_B:    return 16'($urandom_range(1970, 8999));
         ST_C:    return 16'($urandom_range(331, 1610));
         ST_D:    return 16'($urandom_range(166, 269));
         default: return 16'($urandom_range(0, 134));
      endcase
   endfunction

   function automatic item_type zone_tick(pilot_type zone, logic [16:0] ma);
      return roughen(make_tick(pick_res(zone), ma, rand_step()));
   endfunction

   function automatic item_type noise_tick();
      item_type it;
      it = make_tick(16'($urandom_range(0, 65535)), pick_ma(), rand_step());
      it.pe_error             = ($urandom_range(0, 3) == 0);
      it.dc_leak_error        = ($urandom_range(0, 3) == 0);
      it.contactor_error      = ($urandom_range(0, 3) == 0);
      it.jumper_invalid       = ($urandom_range(0, 3) == 0);
      it.cp_usable            = 1'($urandom_range(0, 1));
      it.measurement_settling = ($urandom_range(0, 3) == 0);
      it.phase_switch_busy    = ($urandom_range(0, 3) == 0);
      it.vcp1_negative_mv     = 16'(-int'($urandom_range(0, 20000)));
      it.vcp2_negative_mv     = 16'(-int'($urandom_range(0, 20000)));
      return it;
   endfunction

   task automatic charge_session();
      repeat ($urandom_range(1, 4)) send(zone_tick(ST_A, pick_ma()));
      repeat ($urandom_range(1, 6)) send(zone_tick(ST_B, pick_ma()));
      if ($urandom_range(0, 2) == 0) tick_ms += 32'($urandom_range(35000, 70000));
      repeat ($urandom_range(2, 20)) begin
         send(zone_tick(ST_C, $urandom_range(0, 5) == 0 ? pick_ma() : pick_live_ma()));
      end
      repeat ($urandom_range(1, 4)) begin
         send(zone_tick($urandom_range(0, 1) ? ST_B : ST_A, pick_ma()));
      end
   endtask

   task automatic diode_burst();
      int n;
      n = ($urandom_range(0, 1) == 0) ? $urandom_range(100, 115) : $urandom_range(1, 30);
      repeat (2) send(zone_tick(ST_B, pick_live_ma()));
      tick_ms += 32'($urandom_range(0, 70000));
      repeat (3) send(zone_tick(ST_C, pick_live_ma()));
      repeat (n) send(roughen(make_diode(make_tick(pick_res(ST_C), pick_live_ma(),
                                                    rand_step()))));
      repeat ($urandom_range(1, n + 5)) begin
         send(zone_tick($urandom_range(0, 3) == 0 ? pilot_type'($urandom_range(0, 4))
                                                  : ST_C, pick_live_ma()));
      end
   endtask

   task automatic fault_run();
      item_type    it;
      logic [3:0]  flags;
      repeat ($urandom_range(1, 5)) begin
         it = zone_tick(pilot_type'($urandom_range(0, 4)), pick_ma());
         flags = 4'($urandom_range(1, 15));
         {it.pe_error, it.dc_leak_error, it.contactor_error, it.jumper_invalid} = flags;
         send(it);
      end
      repeat ($urandom_range(1, 6)) send(zone_tick(pilot_type'($urandom_range(0, 4)), pick_ma()));
   endtask

   task automatic random_phase(int count);
      int stop;
      stop = sent + count;
      while (sent < stop) begin
         calm = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: charge_session();
            4, 5:       diode_burst();
            6:          fault_run();
            7: repeat ($urandom_range(3, 10)) begin
               send(zone_tick(pilot_type'($urandom_range(0, 4)), pick_ma()));
            end
            8:          repeat ($urandom_range(1, 8)) send(noise_tick());
            default: begin
               settle();
               repeat ($urandom_range(1, 3)) begin
                  send(zone_tick(pilot_type'($urandom_range(0, 4)), pick_ma()));
               end
            end
         endcase
      end
   endtask

   task automatic new_setting(logic [15:0] err_v, logic [15:0] rst_v, logic [31:0] start_ms);
      settle();
      write_reg(CSR_ERROR_HOLDOFF, err_v);
      write_reg(CSR_RESTART_HOLDOFF, rst_v);
      tick_ms = start_ms;
   endtask

   initial begin
      item_type it;
      req_bus.valid                = 1'b0;
      req_bus.now_ms               = '0;
      req_bus.pe_error             = 1'b0;
      req_bus.dc_leak_error        = 1'b0;
      req_bus.contactor_error      = 1'b0;
      req_bus.jumper_invalid       = 1'b0;
      req_bus.cp_usable            = 1'b0;
      req_bus.cp_resistance        = '0;
      req_bus.max_current_ma       = '0;
      req_bus.vcp1_negative_mv     = '0;
      req_bus.vcp2_negative_mv     = '0;
      req_bus.measurement_settling = 1'b0;
      req_bus.phase_switch_busy    = 1'b0;
      csr_bus.valid                = 1'b0;
      csr_bus.index                = CSR_ERROR_HOLDOFF;
      csr_bus.data                 = '0;
      tick_ms                      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(make_tick(16'd65535, 17'd0, 10));
      send(make_tick(16'd2700, 17'd16000, 10));
      send(make_tick(16'd880, 17'd16000, 10));
      send(make_tick(16'd880, 17'd0, 10));
      // restart holdoff still running
      send(make_tick(16'd880, 17'd80000, 10));
      send(make_tick(16'd880, 17'd51000, 6000));
      send(make_tick(16'd880, 17'd51001, 10));
      send(make_tick(16'd880, 17'd1, 10));
      send(make_tick(16'd880, 17'd131071, 10));
      it = make_tick(16'd65535, 17'd16000, 10);
      it.measurement_settling = 1'b1;
      send(it);
      it = make_tick(16'd65535, 17'd16000, 10);
      it.phase_switch_busy = 1'b1;
      send(it);
      it = make_tick(16'd0, 17'd16000, 10);
      it.cp_usable = 1'b0;
      send(it);
      it = make_tick(16'd880, 17'd16000, 10);
      it.vcp1_negative_mv = -16'sd5000;
      it.vcp2_negative_mv = -16'sd5000;
      send(it);
      send(make_tick(16'd880, 17'd16000, 10));
      send(make_tick(16'd200, 17'd16000, 10));
      send(make_tick(16'd0, 17'd16000, 10));
      it = make_tick(16'd2700, 17'd16000, 10);
      it.pe_error = 1'b1;
      send(it);
      it = make_tick(16'd2700, 17'd16000, 10);
      it.dc_leak_error = 1'b1;
      send(it);
      it = make_tick(16'd2700, 17'd16000, 10);
      it.contactor_error = 1'b1;
      send(it);
      it = make_tick(16'd2700, 17'd16000, 10);
      it.jumper_invalid = 1'b1;
      send(it);
      send(make_tick(16'd2700, 17'd16000, 10));
      // error holdoff blocks C, then lets it through
      send(make_tick(16'd880, 17'd16000, 10));
      send(make_tick(16'd880, 17'd16000, 31000));

      random_phase(190);
      new_setting(16'd0, 16'd0, $urandom());
      random_phase(190);
      new_setting(16'd65535, 16'd65535, 32'hFFFF_F000);
      random_phase(190);
      new_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), $urandom());
      random_phase(190);
      new_setting(16'd1000, 16'd300, $urandom());
      random_phase(190);

      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("ev_charge_pilot_state_machine regression: pass");
      end else begin
         $display("ev_charge_pilot_state_machine regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/ecp_pkg.sv
design/ecp_if.sv
design/ecp_duty.sv
design/ecp_step.sv
design/ev_charge_pilot_state_machine.sv
bench/pilot_checker.sv
bench/tb.sv
